// ===== rtl/rglc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rglc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 31;
  localparam int unsigned LCM_W           = 63;

  localparam logic [LCM_W-1:0] LCM_MAX = {LCM_W{1'b1}};

  // commands from the top level to the sequencer
  typedef struct packed {
    logic start;
    logic ack;
  } rglc_cmd_t;

  // sequencer status
  typedef struct packed {
    logic idle;
    logic done;
  } rglc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/rglc_addsub.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rglc_addsub (
  input  wire logic [rglc_pkg::LCM_W-1:0] a_i,
  input  wire logic [rglc_pkg::LCM_W-1:0] b_i,
  input  wire logic                       sub_i,
  output logic      [rglc_pkg::LCM_W:0]   res_o
);

  logic [rglc_pkg::LCM_W:0] a_ext;
  logic [rglc_pkg::LCM_W:0] b_ext;

  assign a_ext = {1'b0, a_i};
  assign b_ext = {1'b0, b_i};

  // top bit is the carry on add and the borrow on subtract
  assign res_o = sub_i ? (a_ext - b_ext) : (a_ext + b_ext);

endmodule

`default_nettype wire

// ===== rtl/rglc_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rglc_engine #(
  parameter int unsigned VALUE_WIDTH = rglc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rglc_pkg::rglc_cmd_t        cmd_i,
  input  wire logic [VALUE_WIDTH-1:0]     value_i,
  input  wire logic                       first_i,
  input  wire logic [VALUE_WIDTH-1:0]     gcd_acc_i,
  input  wire logic [rglc_pkg::LCM_W-1:0] lcm_acc_i,
  input  wire logic                       ovf_seen_i,
  output rglc_pkg::rglc_sts_t             sts_o,
  output logic      [VALUE_WIDTH-1:0]     gcd_o,
  output logic      [rglc_pkg::LCM_W-1:0] lcm_o,
  output logic                            ovf_o
);

  localparam int unsigned LW    = rglc_pkg::LCM_W;
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned PAD_W = LW - VALUE_WIDTH;

  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(VALUE_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_SHL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]             state_q, state_d;
  logic                   pass_q, pass_d;
  logic [LW-1:0]          u_q, u_d;
  logic [LW-1:0]          v_q, v_d;
  logic [LW-1:0]          w_q, w_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] x_q, x_d;
  logic [VALUE_WIDTH-1:0] gcd_q, gcd_d;
  logic [CNT_W-1:0]       k_q, k_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;

  logic [LW-1:0] op_a;
  logic [LW-1:0] op_b;
  logic          op_sub;
  logic [LW:0]   res;
  logic [LW-1:0] rem_sh;
  logic [LW-1:0] dbl;
  logic [VALUE_WIDTH-1:0] x_in;
  logic          borrow;
  logic          mul_ovf;

  assign rem_sh = {w_q[LW-2:0], quo_q[VALUE_WIDTH-1]};
  assign dbl    = {w_q[LW-2:0], 1'b0};
  assign x_in   = (value_i == '0) ? VALUE_WIDTH'(1) : value_i;
  assign borrow = res[LW];
  assign mul_ovf = ovf_q | w_q[LW-1] | res[LW];

  // operand select for the shared adder
  always_comb begin
    op_a   = u_q;
    op_b   = v_q;
    op_sub = 1'b1;
    case (state_q)
      S_DIV: begin
        op_a = rem_sh;
        op_b = v_q;
      end
      S_MUL: begin
        op_a   = dbl;
        op_b   = quo_q[VALUE_WIDTH-1] ? lcm_acc_i : '0;
        op_sub = 1'b0;
      end
      default: begin
        op_a = u_q;
      end
    endcase
  end

  rglc_addsub u_addsub (
    .a_i   (op_a),
    .b_i   (op_b),
    .sub_i (op_sub),
    .res_o (res)
  );

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    u_d     = u_q;
    v_d     = v_q;
    w_d     = w_q;
    quo_d   = quo_q;
    x_d     = x_q;
    gcd_d   = gcd_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_i.start) begin
          x_d = x_in;
          if (first_i || (lcm_acc_i == '0)) begin
            gcd_d   = x_in;
            w_d     = {{PAD_W{1'b0}}, x_in};
            ovf_d   = 1'b0;
            state_d = S_DONE;
          end else begin
            u_d     = {{PAD_W{1'b0}}, x_in};
            v_d     = {{PAD_W{1'b0}}, gcd_acc_i};
            k_d     = '0;
            pass_d  = 1'b0;
            state_d = S_GCD;
          end
        end
      end
      // binary gcd: one shift, swap or subtract per cycle
      S_GCD: begin
        if (res == '0) begin
          state_d = S_SHL;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + CNT_W'(1);
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (borrow) begin
          u_d = v_q;
          v_d = u_q;
        end else begin
          u_d = {1'b0, res[LW-1:1]};
        end
      end
      // restore the common factors of two, then move on to the next pass, the divide or done
      S_SHL: begin
        if (k_q != '0) begin
          u_d = u_q << 1;
          k_d = k_q - CNT_W'(1);
        end else if (!pass_q) begin
          gcd_d = u_q[VALUE_WIDTH-1:0];
          if (ovf_seen_i) begin
            w_d     = lcm_acc_i;
            ovf_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            u_d     = lcm_acc_i;
            v_d     = {{PAD_W{1'b0}}, x_q};
            k_d     = '0;
            pass_d  = 1'b1;
            state_d = S_GCD;
          end
        end else begin
          v_d     = u_q;
          w_d     = '0;
          quo_d   = x_q;
          cnt_d   = CNT_LOAD;
          state_d = S_DIV;
        end
      end
      // restoring divide x / g, one quotient bit per cycle
      S_DIV: begin
        w_d   = borrow ? rem_sh : res[LW-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], ~borrow};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          w_d     = '0;
          ovf_d   = 1'b0;
          cnt_d   = CNT_LOAD;
          state_d = S_MUL;
        end
      end
      // shift-add lcm * (x / g), msb first, with sticky overflow
      S_MUL: begin
        w_d   = res[LW-1:0];
        ovf_d = mul_ovf;
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          if (mul_ovf) begin
            w_d = rglc_pkg::LCM_MAX;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (cmd_i.ack) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q <= pass_d;
    u_q    <= u_d;
    v_q    <= v_d;
    w_q    <= w_d;
    quo_q  <= quo_d;
    x_q    <= x_d;
    gcd_q  <= gcd_d;
    k_q    <= k_d;
    cnt_q  <= cnt_d;
    ovf_q  <= ovf_d;
  end

  assign sts_o.idle = (state_q == S_IDLE);
  assign sts_o.done = (state_q == S_DONE);
  assign gcd_o      = gcd_q;
  assign lcm_o      = w_q;
  assign ovf_o      = ovf_q;

endmodule

`default_nettype wire

// ===== rtl/running_gcd_lcm_core.sv =====
// channel  | handshake                | payload
// ---------+--------------------------+---------------------------------------------
// input    | in_valid_i / in_ready_o  | value_i, first_i
// output   | out_valid_o / out_ready_i| running_gcd_o, running_lcm_o, lcm_overflow_o
//
// a value that opens a set goes straight to the done state, with no gcd pass
// otherwise two binary gcd passes run on the shared adder (the first on the
// running gcd, the second on the running lcm), then a restoring divide and a
// shift-add multiply; once the overflow flag is set only the first pass runs
// in_ready_o is high only while the sequencer is idle; a finished result waits
// in the sequencer until the output register is free
// reset clears the running gcd, lcm and overflow flag (no set open)
`timescale 1ns / 1ps
`default_nettype none

module running_gcd_lcm_core #(
  parameter int unsigned VALUE_WIDTH = rglc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [VALUE_WIDTH-1:0]     value_i,
  input  wire logic                       first_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [VALUE_WIDTH-1:0]     running_gcd_o,
  output logic      [rglc_pkg::LCM_W-1:0] running_lcm_o,
  output logic                            lcm_overflow_o
);

  rglc_pkg::rglc_cmd_t eng_cmd;
  rglc_pkg::rglc_sts_t eng_sts;

  logic [VALUE_WIDTH-1:0]     eng_gcd;
  logic [rglc_pkg::LCM_W-1:0] eng_lcm;
  logic                       eng_ovf;

  logic                       out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0]     gcd_acc_q, gcd_acc_d;
  logic [rglc_pkg::LCM_W-1:0] lcm_acc_q, lcm_acc_d;
  logic                       ovf_seen_q, ovf_seen_d;

  assign in_ready_o    = eng_sts.idle;
  assign eng_cmd.start = in_valid_i & eng_sts.idle;
  assign eng_cmd.ack   = eng_sts.done & (~out_valid_q | out_ready_i);

  rglc_engine #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (eng_cmd),
    .value_i    (value_i),
    .first_i    (first_i),
    .gcd_acc_i  (gcd_acc_q),
    .lcm_acc_i  (lcm_acc_q),
    .ovf_seen_i (ovf_seen_q),
    .sts_o      (eng_sts),
    .gcd_o      (eng_gcd),
    .lcm_o      (eng_lcm),
    .ovf_o      (eng_ovf)
  );

  // the running state doubles as the output register
  always_comb begin
    out_valid_d = out_valid_q;
    gcd_acc_d   = gcd_acc_q;
    lcm_acc_d   = lcm_acc_q;
    ovf_seen_d  = ovf_seen_q;
    if (eng_cmd.ack) begin
      out_valid_d = 1'b1;
      gcd_acc_d   = eng_gcd;
      lcm_acc_d   = eng_lcm;
      ovf_seen_d  = eng_ovf;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      gcd_acc_q   <= '0;
      lcm_acc_q   <= '0;
      ovf_seen_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      gcd_acc_q   <= gcd_acc_d;
      lcm_acc_q   <= lcm_acc_d;
      ovf_seen_q  <= ovf_seen_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign running_gcd_o  = gcd_acc_q;
  assign running_lcm_o  = lcm_acc_q;
  assign lcm_overflow_o = ovf_seen_q;

`ifndef SYNTHESIS
  a_result_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (running_lcm_o != '0) && (running_gcd_o != '0))
    else $error("result with zero gcd or lcm");

  a_ovf_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcm_overflow_o |-> (running_lcm_o == rglc_pkg::LCM_MAX))
    else $error("overflow flag without saturated lcm");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after a transaction");

  a_state_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !eng_cmd.ack |=> ($stable(lcm_acc_q) && $stable(gcd_acc_q) && $stable(ovf_seen_q)))
    else $error("running state changed without a commit");
`endif

endmodule

`default_nettype wire

// ===== tb/running_gcd_lcm_core_test.sv =====
`timescale 1ns / 1ps

module running_gcd_lcm_core_test;

  localparam int unsigned VW          = rglc_pkg::VALUE_WIDTH_DEF;
  localparam int unsigned LW          = rglc_pkg::LCM_W;
  localparam bit [63:0]   LCM_CEIL    = {1'b0, rglc_pkg::LCM_MAX};
  localparam int unsigned LIMIT_CYC   = 3_000_000;
  localparam int unsigned TAIL_CYC    = 600;
  localparam int unsigned HOLD_CYC    = 2500;
  localparam int unsigned HOLD_AT     = 150;
  localparam int unsigned RANDOM_ITEMS = 1600;

  typedef struct {
    logic [VW-1:0] value;
    logic          first;
    bit            drain;  // wait for all outstanding results before offering
  } send_item_t;

  typedef struct {
    logic [VW-1:0] gcd;
    logic [LW-1:0] lcm;
    logic          ovf;
  } gcd_lcm_t;

  logic          clk_i          = 1'b0;
  logic          rst_ni         = 1'b0;
  logic          in_valid_i     = 1'b0;
  logic [VW-1:0] value_i        = '0;
  logic          first_i        = 1'b0;
  logic          out_ready_i    = 1'b0;
  logic          in_ready_o;
  logic          out_valid_o;
  logic [VW-1:0] running_gcd_o;
  logic [LW-1:0] running_lcm_o;
  logic          lcm_overflow_o;

  send_item_t  values_to_send[$];
  gcd_lcm_t    gcd_lcm_due[$];

  // running state of the predicted block
  bit [VW-1:0] run_gcd = '0;
  bit [63:0]   run_lcm = '0;
  bit          lcm_sat = 1'b0;

  int unsigned cycle_cnt    = 0;
  int unsigned err_cnt      = 0;
  int unsigned total_items  = 0;
  int unsigned accepted_cnt = 0;
  int unsigned results_cnt  = 0;
  int unsigned sets_cnt     = 0;
  int unsigned sat_cnt      = 0;
  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  bit          in_taken     = 1'b0;

  running_gcd_lcm_core #(
    .VALUE_WIDTH(VW)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .first_i       (first_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .running_gcd_o (running_gcd_o),
    .running_lcm_o (running_lcm_o),
    .lcm_overflow_o(lcm_overflow_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit [63:0] euclid_gcd(bit [63:0] a, bit [63:0] b);
    bit [63:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // folds one value into the running gcd and lcm and returns the new pair
  function automatic gcd_lcm_t fold_value(logic [VW-1:0] v, logic start);
    bit [63:0] x;
    bit [63:0] g;
    bit [63:0] q;
    bit [63:0] t;
    gcd_lcm_t  r;
    x = 64'(v);
    if (x == 0) x = 1;  // zero is taken as one
    if (start || run_lcm == 0) begin
      run_gcd = x[VW-1:0];
      run_lcm = x;
      lcm_sat = 1'b0;
      sets_cnt++;
    end else begin
      t = euclid_gcd(x, 64'(run_gcd));
      run_gcd = t[VW-1:0];
      if (!lcm_sat) begin
        g = euclid_gcd(run_lcm, x);
        q = run_lcm / g;
        if (q > LCM_CEIL / x) begin
          run_lcm = LCM_CEIL;
          lcm_sat = 1'b1;
        end else begin
          run_lcm = q * x;
        end
      end
    end
    r.gcd = run_gcd;
    r.lcm = run_lcm[LW-1:0];
    r.ovf = lcm_sat;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    // quiet window with no idling at all
    if ((cycle_cnt % 20000) >= 15000) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void add_item(logic [VW-1:0] v, logic f, bit d = 1'b0);
    send_item_t it;
    it.value = v;
    it.first = f;
    it.drain = d;
    values_to_send.push_back(it);
    total_items++;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // input driver
  always @(negedge clk_i) begin
    send_item_t nxt;
    bit         was_taken;
    if (rst_ni) begin
      was_taken = in_taken;
      in_taken  = 1'b0;
      if (was_taken) send_gap = pick_gap();
      if (in_valid_i && !was_taken) begin
        // transaction still waiting for ready, hold payload
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (values_to_send.size() > 0 &&
                   !(values_to_send[0].drain && gcd_lcm_due.size() > 0)) begin
        nxt = values_to_send.pop_front();
        in_valid_i <= 1'b1;
        value_i    <= nxt.value;
        first_i    <= nxt.first;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output ready with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && accepted_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // monitor: predicts on input transactions, checks output transactions
  always @(posedge clk_i) begin
    gcd_lcm_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        gcd_lcm_due.push_back(fold_value(value_i, first_i));
        in_taken = 1'b1;
        accepted_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        results_cnt++;
        if (gcd_lcm_due.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          want = gcd_lcm_due.pop_front();
          if (want.ovf) sat_cnt++;
          if (running_gcd_o !== want.gcd || running_lcm_o !== want.lcm ||
              lcm_overflow_o !== want.ovf) begin
            report_mismatch($sformatf("result %0d gcd %0d/%0d lcm %0d/%0d ovf %0b/%0b",
                                      results_cnt, running_gcd_o, want.gcd,
                                      running_lcm_o, want.lcm, lcm_overflow_o, want.ovf));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYC) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               gcd_lcm_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned base;
    int unsigned hi;
    int unsigned k;
    logic [VW-1:0] v;
    logic          f;

    // no set open after reset, value without start flag opens one
    add_item(12, 1'b0);
    add_item(18, 1'b0);
    add_item(0, 1'b0);
    add_item(12, 1'b0);
    add_item(1, 1'b1);
    add_item('1, 1'b0);
    add_item('h7FFFFFFE, 1'b0);
    add_item('h7FFFFFFD, 1'b0);  // pushes the lcm past 63 bits
    add_item(6, 1'b0);
    add_item('1, 1'b0);
    add_item(0, 1'b1);
    add_item('h55555555, 1'b0);
    add_item('h2AAAAAAA, 1'b0);
    // saturated set where the gcd keeps moving
    add_item('h7FF00000, 1'b1);
    add_item('h7FE00000, 1'b0);
    add_item('h7FD00000, 1'b0);
    add_item('h7FB00000, 1'b0);
    add_item('h7F700000, 1'b0);
    add_item('h40000000, 1'b0);
    add_item('h00300000, 1'b0);
    add_item('h00080000, 1'b0);
    add_item('1, 1'b1);
    add_item('1, 1'b0);
    add_item(1, 1'b0);

    while (total_items < RANDOM_ITEMS + 24) begin
      kind = $urandom_range(0, 9);
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 7);
      base = $urandom_range(1, ($urandom_range(0, 1) != 0) ? 16 : 5000);
      hi   = 32'h7FFF_FFFF / base;
      for (k = 0; k < len; k++) begin
        f = (k == 0);
        case (kind)
          0, 1, 2, 3: v = VW'(base * $urandom_range(1, ($urandom_range(0, 2) == 0) ? hi : 64));
          4, 5:       v = VW'($urandom_range(1, 64));
          6, 7, 8:    v = VW'($urandom);
          default: begin
            // noise: start flags at random, odd values
            f = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
              0:       v = '0;
              1:       v = '1;
              2:       v = VW'($urandom_range(1, 8));
              default: v = VW'($urandom);
            endcase
          end
        endcase
        if ($urandom_range(0, 59) == 0) v = '0;
        add_item(v, f, total_items == 24 || total_items == 500 || total_items == 1100);
      end
    end

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt < total_items || gcd_lcm_due.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);

    $display("%0d values in %0d sets checked, %0d results with a saturated lcm",
             accepted_cnt, sets_cnt, sat_cnt);
    $display("%0d results compared in %0d cycles, %0d mismatches",
             results_cnt, cycle_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
